### rtl/sdcmd_pkg.sv
// Shared types, codes and constants for the SD-card SPI-mode command engine.
// Used by every module of the block; it depends on nothing else.
package sdcmd_pkg;

    // Input item selector carried on s_tuser.
    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_TICK  = 2'd2
    } action_t;

    // Result kind carried on m_tuser.
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_FINISH  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_READY_TIMEOUT = 1'b0;
    localparam logic CFG_RESP_ATTEMPTS = 1'b1;

    // Transaction sequencer phases.
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_DESEL    = 4'd1,
        PH_SEL      = 4'd2,
        PH_READY    = 4'd3,
        PH_TO_DESEL = 4'd4,
        PH_CMD      = 4'd5,
        PH_STUFF    = 4'd6,
        PH_RESP     = 4'd7
    } phase_t;

    localparam logic [5:0] IDX_GO_IDLE    = 6'd0;
    localparam logic [5:0] IDX_SEND_IF    = 6'd8;
    localparam logic [5:0] IDX_STOP       = 6'd12;
    localparam logic [5:0] IDX_APP_PREFIX = 6'd55;

    localparam logic [7:0] BYTE_FILL     = 8'hFF;
    localparam logic [7:0] CMD_START     = 8'h40;
    localparam logic [7:0] CRC_GO_IDLE   = 8'h95;
    localparam logic [7:0] CRC_SEND_IF   = 8'h87;
    localparam logic [7:0] CRC_DUMMY     = 8'h01;
    localparam logic [7:0] R1_IDLE_LIMIT = 8'h01;
    localparam logic [7:0] LAST_ARG_POS  = 8'd5;

    typedef struct packed {
        action_t     action;
        logic [5:0]  cmd_index;
        logic        app_command;
        logic [31:0] argument;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       chip_select_low;
        logic [7:0] response;
        logic       timed_out;
    } result_t;

    // Byte k of the six-byte command frame: start/index, argument MSB first, CRC.
    function automatic logic [7:0] command_byte(input logic [2:0] k,
                                                input logic [5:0] idx,
                                                input logic [31:0] arg);
        logic [7:0] b;
        case (k)
            3'd0: b = CMD_START | {2'b00, idx};
            3'd1: b = arg[31:24];
            3'd2: b = arg[23:16];
            3'd3: b = arg[15:8];
            3'd4: b = arg[7:0];
            default: begin
                if (idx == IDX_GO_IDLE) begin
                    b = CRC_GO_IDLE;
                end else if (idx == IDX_SEND_IF) begin
                    b = CRC_SEND_IF;
                end else begin
                    b = CRC_DUMMY;
                end
            end
        endcase
        return b;
    endfunction

endpackage

### rtl/sd_spi_command_engine_core.sv
// Top level of the SD-card SPI-mode command engine: stream ports, configuration
// registers and the result register. Depends on sdcmd_pkg, sdcmd_in_stage and
// sdcmd_engine.

// This block sequences one SD-card SPI-mode command, one byte exchange per
// transaction. A start transaction (tuser 0) while idle latches the command
// index, the application-command flag and the argument; each byte transaction
// (tuser 1) during a command reports the byte just received and is answered
// with the next byte to send and the chip-select level, or with a finished
// result carrying the R1 response and the timeout flag. Timer-tick transactions
// (tuser 2) count down the ready timeout and produce no result. Each
// transaction is taken into an input register and resolved in one pass of
// logic into the result register, so the block accepts one transaction per
// clock cycle for as long as the result side takes its data. A result thus
// passes through the input register and then the result register before it
// can be taken. Configuration writes are meant to be made only while no
// command is in progress.
module sd_spi_command_engine_core import sdcmd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [5:0] cmd_index, [6] app_command, [38:7] argument, [46:39] rx_byte,
    // [47] zero fill
    input  logic [47:0] s_tdata,
    // [1:0] action
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] tx_byte, [8] chip_select_low, [16:9] response, [17] timed_out,
    // [23:18] zero fill
    output logic [23:0] m_tdata,
    // [0] kind
    output logic        m_tuser,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] ready_timeout_reg;
    logic [7:0]  resp_attempts_reg;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    logic    fire;
    logic    res_valid;
    result_t res;

    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg;

    // Configuration registers are always writable.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_timeout_reg <= 16'd50;
            resp_attempts_reg <= 8'd10;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_READY_TIMEOUT) begin
                ready_timeout_reg <= cfg_data;
            end else if (cfg_index == CFG_RESP_ATTEMPTS) begin
                resp_attempts_reg <= cfg_data[7:0];
            end
        end
    end

    // Unpack the input transaction.
    assign in_item.action      = action_t'(s_tuser);
    assign in_item.cmd_index   = s_tdata[5:0];
    assign in_item.app_command = s_tdata[6];
    assign in_item.argument    = s_tdata[38:7];
    assign in_item.rx_byte     = s_tdata[46:39];

    // The engine may consume its item whenever the result register is free or
    // being emptied in this cycle.
    assign take = !m_valid_reg || m_tready;
    assign fire = item_valid && take;

    sdcmd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    sdcmd_engine u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .item          (item),
        .ready_timeout (ready_timeout_reg),
        .resp_attempts (resp_attempts_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    // Result register.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire && res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.kind;
    assign m_tdata  = {6'd0, m_res_reg.timed_out, m_res_reg.response,
                       m_res_reg.chip_select_low, m_res_reg.tx_byte};

endmodule

### rtl/sdcmd_in_stage.sv
// Input register of the command engine: holds one accepted item until the
// engine consumes it. Depends on sdcmd_pkg for the item type.
module sdcmd_in_stage import sdcmd_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  take,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The slot frees in the same cycle that the engine takes its item.
    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

### rtl/sdcmd_engine.sv
// Command sequencer: phase machine, byte counter, held command and ready
// timer, with the single-pass logic that turns one item into at most one result.
// Depends on sdcmd_pkg.
module sdcmd_engine import sdcmd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  item_t       item,
    input  logic [15:0] ready_timeout,
    input  logic [7:0]  resp_attempts,
    output logic        res_valid,
    output result_t     res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [5:0]  held_index_reg, held_index_next;
    logic [31:0] held_argument_reg, held_argument_next;
    logic        prefix_pending_reg, prefix_pending_next;
    logic [15:0] ticks_left_reg, ticks_left_next;
    logic        select_level_reg, select_level_next;

    logic [5:0]  cur_index;
    logic [31:0] cur_argument;
    logic [5:0]  start_index;
    logic [7:0]  count_inc;
    logic        resp_more;
    logic        prefix_ok;

    assign cur_index    = prefix_pending_reg ? IDX_APP_PREFIX : held_index_reg;
    assign cur_argument = prefix_pending_reg ? 32'd0 : held_argument_reg;
    assign start_index  = item.app_command ? IDX_APP_PREFIX : item.cmd_index;
    assign count_inc    = byte_count_reg + 8'd1;
    assign resp_more    = item.rx_byte[7] && (count_inc < resp_attempts);
    // After a successful CMD55 the real command starts right away.
    assign prefix_ok    = prefix_pending_reg && (item.rx_byte <= R1_IDLE_LIMIT);

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (fire) begin
            case (item.action)
                ACT_START: begin
                    if (phase_reg == PH_IDLE) begin
                        phase_next = (start_index != IDX_STOP) ? PH_DESEL : PH_CMD;
                    end
                end
                ACT_BYTE: begin
                    unique case (phase_reg)
                        PH_IDLE:     phase_next = PH_IDLE;
                        PH_DESEL:    phase_next = PH_SEL;
                        PH_SEL:      phase_next = PH_READY;
                        PH_READY: begin
                            if (item.rx_byte == BYTE_FILL) begin
                                phase_next = PH_CMD;
                            end else if (ticks_left_reg == 16'd0) begin
                                phase_next = PH_TO_DESEL;
                            end
                        end
                        PH_TO_DESEL: phase_next = PH_IDLE;
                        PH_CMD: begin
                            if (count_inc > LAST_ARG_POS) begin
                                phase_next = (cur_index == IDX_STOP) ? PH_STUFF : PH_RESP;
                            end
                        end
                        PH_STUFF:    phase_next = PH_RESP;
                        PH_RESP: begin
                            if (!resp_more) begin
                                if (prefix_ok) begin
                                    phase_next = (held_index_reg != IDX_STOP) ?
                                                 PH_DESEL : PH_CMD;
                                end else begin
                                    phase_next = PH_IDLE;
                                end
                            end
                        end
                        default:     phase_next = PH_IDLE;
                    endcase
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    // Datapath registers and the result.
    always_comb begin
        byte_count_next     = byte_count_reg;
        held_index_next     = held_index_reg;
        held_argument_next  = held_argument_reg;
        prefix_pending_next = prefix_pending_reg;
        ticks_left_next     = ticks_left_reg;
        select_level_next   = select_level_reg;
        res_valid           = 1'b0;
        res.kind            = KIND_REQUEST;
        res.tx_byte         = BYTE_FILL;
        res.response        = 8'd0;
        res.timed_out       = 1'b0;

        if (fire) begin
            case (item.action)
                ACT_TICK: begin
                    if (ticks_left_reg != 16'd0) begin
                        ticks_left_next = ticks_left_reg - 16'd1;
                    end
                end
                ACT_START: begin
                    if (phase_reg == PH_IDLE) begin
                        held_index_next     = item.cmd_index;
                        held_argument_next  = item.argument;
                        prefix_pending_next = item.app_command;
                        byte_count_next     = 8'd0;
                        res_valid           = 1'b1;
                        if (start_index != IDX_STOP) begin
                            select_level_next = 1'b0;
                        end else begin
                            res.tx_byte = command_byte(3'd0, start_index, 32'd0);
                        end
                    end
                end
                ACT_BYTE: begin
                    res_valid = (phase_reg != PH_IDLE);
                    unique case (phase_reg)
                        PH_IDLE: begin
                        end
                        PH_DESEL: begin
                            select_level_next = 1'b1;
                        end
                        PH_SEL: begin
                            ticks_left_next = ready_timeout;
                        end
                        PH_READY: begin
                            if (item.rx_byte == BYTE_FILL) begin
                                byte_count_next = 8'd0;
                                res.tx_byte = command_byte(3'd0, cur_index, cur_argument);
                            end else if (ticks_left_reg == 16'd0) begin
                                select_level_next = 1'b0;
                            end
                        end
                        PH_TO_DESEL: begin
                            prefix_pending_next = 1'b0;
                            res.kind      = KIND_FINISH;
                            res.tx_byte   = 8'd0;
                            res.response  = BYTE_FILL;
                            res.timed_out = 1'b1;
                        end
                        PH_CMD: begin
                            if (count_inc > LAST_ARG_POS) begin
                                byte_count_next = 8'd0;
                            end else begin
                                byte_count_next = count_inc;
                                res.tx_byte = command_byte(count_inc[2:0], cur_index,
                                                           cur_argument);
                            end
                        end
                        PH_STUFF: begin
                            byte_count_next = 8'd0;
                        end
                        PH_RESP: begin
                            byte_count_next = count_inc;
                            if (!resp_more) begin
                                prefix_pending_next = 1'b0;
                                if (prefix_ok) begin
                                    if (held_index_reg != IDX_STOP) begin
                                        select_level_next = 1'b0;
                                    end else begin
                                        byte_count_next = 8'd0;
                                        res.tx_byte = command_byte(3'd0, held_index_reg,
                                                                   held_argument_reg);
                                    end
                                end else begin
                                    res.kind     = KIND_FINISH;
                                    res.tx_byte  = 8'd0;
                                    res.response = item.rx_byte;
                                end
                            end
                        end
                        default: begin
                            res_valid = 1'b0;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
        res.chip_select_low = select_level_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_IDLE;
            byte_count_reg     <= 8'd0;
            held_index_reg     <= 6'd0;
            held_argument_reg  <= 32'd0;
            prefix_pending_reg <= 1'b0;
            ticks_left_reg     <= 16'd0;
            select_level_reg   <= 1'b0;
        end else begin
            phase_reg          <= phase_next;
            byte_count_reg     <= byte_count_next;
            held_index_reg     <= held_index_next;
            held_argument_reg  <= held_argument_next;
            prefix_pending_reg <= prefix_pending_next;
            ticks_left_reg     <= ticks_left_next;
            select_level_reg   <= select_level_next;
        end
    end

endmodule

### sim/sdcmd_checker.sv
// Scoreboard for the SD-card SPI-mode command engine: watches the input, result and
// register channels, predicts every result and compares it field by field.
// Depends on sdcmd_pkg for the item and result layouts and the codes.
module sdcmd_checker import sdcmd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output logic        cmd_busy,
    output int          results_seen,
    output int          finishes_seen,
    output int          timeouts_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    phase_t      seq_phase;
    logic [7:0]  frame_pos;
    logic [5:0]  latched_index;
    logic [31:0] latched_arg;
    logic        prefix_due;
    logic [15:0] ready_ticks;
    logic        cs_low;
    logic [15:0] timeout_reg;
    logic [7:0]  attempts_reg;
    result_t     expected_q[$];

    assign pending  = expected_q.size();
    assign cmd_busy = (seq_phase != PH_IDLE);

    // While the CMD55 prefix runs, the frame carries index 55 and a zero argument.
    function automatic logic [5:0] live_index();
        return prefix_due ? IDX_APP_PREFIX : latched_index;
    endfunction

    function automatic logic [7:0] frame_byte(input logic [7:0] pos);
        logic [31:0] arg;
        arg = prefix_due ? 32'd0 : latched_arg;
        if (pos == 8'd0) begin
            return CMD_START | {2'b00, live_index()};
        end
        if (pos <= 8'd4) begin
            return 8'(arg >> (8 * (4 - pos)));
        end
        if (live_index() == IDX_GO_IDLE) begin
            return CRC_GO_IDLE;
        end
        return (live_index() == IDX_SEND_IF) ? CRC_SEND_IF : CRC_DUMMY;
    endfunction

    task automatic queue_request(input logic [7:0] tx);
        result_t r;
        r = '0;
        r.kind = KIND_REQUEST;
        r.tx_byte = tx;
        r.chip_select_low = cs_low;
        expected_q.push_back(r);
    endtask

    task automatic queue_finish(input logic [7:0] resp, input logic expired);
        result_t r;
        seq_phase = PH_IDLE;
        prefix_due = 1'b0;
        r = '0;
        r.kind = KIND_FINISH;
        r.chip_select_low = cs_low;
        r.response = resp;
        r.timed_out = expired;
        expected_q.push_back(r);
    endtask

    // CMD12 goes straight to its frame on the current chip-select level.
    task automatic open_command();
        if (live_index() != IDX_STOP) begin
            cs_low = 1'b0;
            seq_phase = PH_DESEL;
            queue_request(BYTE_FILL);
        end else begin
            seq_phase = PH_CMD;
            frame_pos = 8'd0;
            queue_request(frame_byte(8'd0));
        end
    endtask

    task automatic close_command(input logic [7:0] r1);
        if (prefix_due) begin
            prefix_due = 1'b0;
            if (r1 > R1_IDLE_LIMIT) begin
                queue_finish(r1, 1'b0);
            end else begin
                open_command();
            end
        end else begin
            queue_finish(r1, 1'b0);
        end
    endtask

    task automatic advance_on_byte(input logic [7:0] rx);
        case (seq_phase)
            PH_DESEL: begin
                cs_low = 1'b1;
                seq_phase = PH_SEL;
                queue_request(BYTE_FILL);
            end
            PH_SEL: begin
                ready_ticks = timeout_reg;
                seq_phase = PH_READY;
                queue_request(BYTE_FILL);
            end
            PH_READY: begin
                if (rx == BYTE_FILL) begin
                    seq_phase = PH_CMD;
                    frame_pos = 8'd0;
                    queue_request(frame_byte(8'd0));
                end else if (ready_ticks == 16'd0) begin
                    cs_low = 1'b0;
                    seq_phase = PH_TO_DESEL;
                    queue_request(BYTE_FILL);
                end else begin
                    queue_request(BYTE_FILL);
                end
            end
            PH_TO_DESEL: queue_finish(BYTE_FILL, 1'b1);
            PH_CMD: begin
                frame_pos = frame_pos + 8'd1;
                if (frame_pos <= LAST_ARG_POS) begin
                    queue_request(frame_byte(frame_pos));
                end else begin
                    frame_pos = 8'd0;
                    if (live_index() == IDX_STOP) begin
                        seq_phase = PH_STUFF;
                    end else begin
                        seq_phase = PH_RESP;
                    end
                    queue_request(BYTE_FILL);
                end
            end
            PH_STUFF: begin
                seq_phase = PH_RESP;
                frame_pos = 8'd0;
                queue_request(BYTE_FILL);
            end
            PH_RESP: begin
                frame_pos = frame_pos + 8'd1;
                if (rx[7] && frame_pos < attempts_reg) begin
                    queue_request(BYTE_FILL);
                end else begin
                    close_command(rx);
                end
            end
            default: ;
        endcase
    endtask

    task automatic predict_item(input item_t it);
        case (it.action)
            ACT_TICK: begin
                if (ready_ticks != 16'd0) begin
                    ready_ticks = ready_ticks - 16'd1;
                end
            end
            ACT_START: begin
                if (seq_phase == PH_IDLE) begin
                    latched_index = it.cmd_index;
                    latched_arg = it.argument;
                    prefix_due = it.app_command;
                    frame_pos = 8'd0;
                    open_command();
                end
            end
            ACT_BYTE: begin
                if (seq_phase != PH_IDLE) begin
                    advance_on_byte(it.rx_byte);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (expected_q.size() == 0) begin
            $error("result with nothing predicted: kind %0d tdata 0x%0h", got.kind, m_tdata);
            fail_count++;
            return;
        end
        want = expected_q.pop_front();
        check_field("kind", 8'(want.kind), 8'(got.kind));
        check_field("tx_byte", want.tx_byte, got.tx_byte);
        check_field("chip_select_low", 8'(want.chip_select_low), 8'(got.chip_select_low));
        check_field("response", want.response, got.response);
        check_field("timed_out", 8'(want.timed_out), 8'(got.timed_out));
        results_seen++;
        if (got.kind == KIND_FINISH) begin
            finishes_seen++;
        end
        if (got.kind == KIND_FINISH && got.timed_out) begin
            timeouts_seen++;
        end
    endtask

    always @(posedge aclk) begin
        item_t   in_item;
        result_t out_item;
        if (!aresetn) begin
            seq_phase = PH_IDLE;
            frame_pos = 8'd0;
            latched_index = 6'd0;
            latched_arg = 32'd0;
            prefix_due = 1'b0;
            ready_ticks = 16'd0;
            cs_low = 1'b0;
            timeout_reg = 16'd50;
            attempts_reg = 8'd10;
            expected_q.delete();
            fail_count = 0;
            results_seen = 0;
            finishes_seen = 0;
            timeouts_seen = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                out_item.kind = m_tuser;
                out_item.tx_byte = m_tdata[7:0];
                out_item.chip_select_low = m_tdata[8];
                out_item.response = m_tdata[16:9];
                out_item.timed_out = m_tdata[17];
                check_result(out_item);
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_READY_TIMEOUT) begin
                    timeout_reg = cfg_data;
                end else begin
                    attempts_reg = cfg_data[7:0];
                end
            end
            if (s_tvalid && s_tready) begin
                in_item.action = action_t'(s_tuser);
                in_item.cmd_index = s_tdata[5:0];
                in_item.app_command = s_tdata[6];
                in_item.argument = s_tdata[38:7];
                in_item.rx_byte = s_tdata[46:39];
                predict_item(in_item);
            end
        end
    end

endmodule

### sim/sd_spi_command_engine_core_test.sv
// Testbench top for the SD-card SPI-mode command engine: clock, reset, stimulus,
// receiver back-pressure, watchdog and verdict. Depends on sdcmd_pkg, the block
// sd_spi_command_engine_core and the scoreboard sdcmd_checker.
module sd_spi_command_engine_core_test;
    import sdcmd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Extra settle time after the last predicted result covers items such as
    // ticks that leave no result behind.
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    // The longest quiet stretch of a correct run is a receiver stall or a sender
    // gap, so this is far beyond any healthy pause.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_SETTING = 180;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    int          fail_count;
    int          pending;
    logic        cmd_busy;
    int          results_seen;
    int          finishes_seen;
    int          timeouts_seen;

    int          items_sent = 0;
    int          settings_run = 0;
    int          burst_left = 1;
    int          quiet_cycles = 0;
    logic [8:0]  stall_tick = '0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    sd_spi_command_engine_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sdcmd_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .cmd_busy      (cmd_busy),
        .results_seen  (results_seen),
        .finishes_seen (finishes_seen),
        .timeouts_seen (timeouts_seen)
    );

    // The receiver cycles through four back-pressure patterns: always ready,
    // coin flips, ready only when the low three tick bits are zero, and long stalls.
    always @(negedge aclk) begin
        stall_tick <= stall_tick + 9'd1;
        case (stall_tick[8:7])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= 1'($urandom_range(0, 1));
            2'd2: m_tready <= (stall_tick[2:0] == 3'd0);
            default: m_tready <= (stall_tick[4:0] < 5'd8);
        endcase
    end

    // The watchdog ends the run if no transaction of any channel completes
    // for too long after reset.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles.", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Every field gets random bits so that fields the action ignores still
    // toggle; callers override the ones that matter.
    function automatic item_t random_fields(input action_t act);
        item_t it;
        it.action = act;
        it.cmd_index = 6'($urandom);
        it.app_command = 1'($urandom);
        it.argument = $urandom;
        it.rx_byte = 8'($urandom);
        return it;
    endfunction

    // Commands with special handling come up often; the rest are random.
    function automatic logic [5:0] pick_index();
        case ($urandom_range(0, 7))
            0: return IDX_GO_IDLE;
            1: return IDX_SEND_IF;
            2: return IDX_STOP;
            3: return IDX_APP_PREFIX;
            default: return 6'($urandom);
        endcase
    endfunction

    // A card answer: ready bytes, busy bytes with bit 7 set, idle or ready R1
    // values, error R1 values and plain noise.
    function automatic logic [7:0] card_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return BYTE_FILL;
            3, 4: return {1'b1, 7'($urandom)};
            5: return 8'($urandom_range(0, 1));
            6, 7: return {1'b0, 7'($urandom)};
            default: return 8'($urandom);
        endcase
    endfunction

    // Present one transaction from a falling edge and return at the falling
    // edge after it is taken, or after the gap when a burst ends. That gap keeps
    // tvalid low, so tvalid is never dropped and raised again in the same time step.
    task automatic push_item(input item_t it);
        s_tvalid <= 1'b1;
        s_tuser <= it.action;
        s_tdata <= {1'b0, it.rx_byte, it.argument, it.app_command, it.cmd_index};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic send_start(input logic [5:0] idx, input logic app,
                              input logic [31:0] arg);
        item_t it;
        it = random_fields(ACT_START);
        it.cmd_index = idx;
        it.app_command = app;
        it.argument = arg;
        push_item(it);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] rx);
        item_t it;
        it = random_fields(ACT_BYTE);
        it.rx_byte = rx;
        push_item(it);
        items_sent++;
    endtask

    // Hold the sender until every predicted result has come back and the
    // pipeline has run empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Both registers are written back to back, with valid held high between.
    task automatic program_regs(input logic [15:0] ticks, input logic [7:0] tries);
        logic [15:0] vals[2];
        vals[0] = ticks;
        vals[1] = {8'd0, tries};
        for (int i = 0; i < 2; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= (i == 0) ? CFG_READY_TIMEOUT : CFG_RESP_ATTEMPTS;
            cfg_data <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) begin
                @(posedge aclk);
            end
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // One command run as a card would see it: a start, then byte exchanges and
    // ticks until the command finishes. A positive budget cuts the run short;
    // whatever comes next carries it on.
    task automatic run_command(input int budget);
        int    roll;
        if (!cmd_busy) begin
            send_start(pick_index(), ($urandom_range(0, 9) < 3), $urandom);
        end
        while (cmd_busy && budget != 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                // A start while busy is dropped by the block.
                push_item(random_fields(ACT_START));
            end else if (roll < 20) begin
                push_item(random_fields(ACT_TICK));
                items_sent++;
                budget--;
            end else begin
                send_byte(card_byte());
                budget--;
            end
        end
    endtask

    // One register setting: program it while idle, run mostly complete
    // commands with some cut short and some stray items, and leave no
    // command open before the next register write.
    task automatic run_setting(input logic [15:0] ticks, input logic [7:0] tries);
        int goal;
        settle();
        program_regs(ticks, tries);
        goal = items_sent + ITEMS_PER_SETTING;
        while (items_sent < goal) begin
            if ($urandom_range(0, 99) < 12) begin
                push_item(random_fields(action_t'(2'($urandom_range(0, 3)))));
            end else if ($urandom_range(0, 9) == 0) begin
                run_command($urandom_range(1, 6));
            end else begin
                run_command(-1);
            end
        end
        while (cmd_busy) begin
            send_byte(card_byte());
        end
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part at the reset register values. Stray items first: a
        // byte while idle, the unused action code, and a tick with nothing
        // to count down.
        send_byte(BYTE_FILL);
        push_item(random_fields(action_t'(2'd3)));
        push_item(random_fields(ACT_TICK));

        // CMD0 with an all-ones argument: deselect, select, ready at once,
        // the six frame bytes, one filler, then an idle R1. A start in the
        // middle must be ignored.
        send_start(IDX_GO_IDLE, 1'b0, 32'hFFFF_FFFF);
        send_byte(BYTE_FILL);
        send_byte(BYTE_FILL);
        push_item(random_fields(ACT_START));
        send_byte(BYTE_FILL);
        repeat (6) send_byte(8'($urandom));
        send_byte(R1_IDLE_LIMIT);

        // CMD12 with a zero argument: no select sequence, the stuff byte,
        // one busy byte and then a clean R1.
        send_start(IDX_STOP, 1'b0, 32'd0);
        repeat (6) send_byte(8'($urandom));
        send_byte(8'($urandom));
        send_byte(8'h80);
        send_byte(8'h00);

        // Random part over several register settings: both zero, the
        // smallest legal values, both at their maximum, and small values
        // that make ready timeouts and exhausted polls common.
        run_setting(16'd0, 8'd0);
        run_setting(16'd1, 8'd1);
        run_setting(16'hFFFF, 8'hFF);
        run_setting(16'($urandom_range(1, 6)), 8'($urandom_range(1, 4)));
        run_setting(16'd3, 8'hFF);
        run_setting(16'($urandom_range(1, 20)), 8'($urandom_range(1, 12)));
        run_setting(16'd50, 8'd10);

        settle();
        repeat (TAIL_CYCLES) @(negedge aclk);
        $display("Covered %0d items across %0d register settings after a directed opening.",
                 items_sent, settings_run);
        $display("Compared %0d results; %0d commands finished, %0d of them on ready timeout.",
                 results_seen, finishes_seen, timeouts_seen);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
